@@ rtl/core/ntx_pkg.sv @@
// ----------------------------------------------------------------------------
// ntx_pkg
// Shared types and constants of the neighbor table with expiry.
// ----------------------------------------------------------------------------
`default_nettype none
package ntx_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;

	localparam logic [2:0] OP_UPDATE = 3'd0;
	localparam logic [2:0] OP_QUERY  = 3'd1;
	localparam logic [2:0] OP_TXERR  = 3'd2;
	localparam logic [2:0] OP_LOOKUP = 3'd3;
	localparam logic [2:0] OP_PURGE  = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] ip_addr;
		logic [47:0] mac_addr;
		logic [31:0] lifetime;
		logic [31:0] current_time;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] result_ip;
		logic        found;
		logic [31:0] remaining_time;
		logic        table_full;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] expiry;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PURGE,
		ST_ANSWER
	} ntx_state_t;
endpackage
`default_nettype wire

@@ rtl/core/neighbor_table_with_expiry.sv @@
// ----------------------------------------------------------------------------
// neighbor_table_with_expiry
// Ordered neighbor table with expiry, MAC resolution and link-closed reports.
// ----------------------------------------------------------------------------
// An item is taken on start while busy is low; busy stays high until the
// item's answer has been produced. Results leave one per cycle on res with
// res_valid high for one cycle; reports (kind 0) come first, the answer
// (kind 1, last 1) ends every item. The receiver cannot stall.
// Entries live in one RAM with a registered read; every defined operation
// walks the stored entries once at one read per cycle, update walks twice on
// a miss (search, then purge with in-place compaction), with count <= 16.
// A report passes the RAM read register and then the result register.
// report_failures is written on the cfg channel, always ready; the user must
// write it only while idle, which the block itself does not enforce.
// Reset empties the table and clears report_failures; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module neighbor_table_with_expiry (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ntx_pkg::cmd_t cmd,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic          cfg_data,
	output logic               res_valid,
	output ntx_pkg::res_t      res
);
	import ntx_pkg::*;

	ntx_state_t state_q, state_d;
	cmd_t       cmd_q;
	logic [31:0] exp_q;
	logic       report_q;
	logic [CNT_W-1:0] count_q, rd_q, wr_q;
	logic       vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic       hit_q, full_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t     hit_ent_q;
	logic [31:0] rem_q;
	logic       res_valid_q;
	res_t       res_q;

	entry_t     rd_ent, wdata;
	logic       we;
	logic [IDX_W-1:0] waddr;
	logic       res_v;
	res_t       res_d;
	logic       issue, walk_done, gone, match;
	logic [32:0] sum;
	entry_t     merged;

	ntx_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (rd_ent)
	);

	assign sum       = {1'b0, cmd.current_time} + {1'b0, cmd.lifetime};
	assign issue     = (state_q == ST_SCAN || state_q == ST_PURGE) && (rd_q < count_q);
	assign walk_done = !issue && !vld_s1;
	assign gone      = (rd_ent.expiry < cmd_q.current_time)
		|| (cmd_q.op == OP_TXERR && rd_ent.mac == cmd_q.mac_addr);
	assign match     = (cmd_q.op == OP_UPDATE) ? (rd_ent.ip == cmd_q.ip_addr)
		: (rd_ent.mac == cmd_q.mac_addr);

	always_comb begin
		merged.ip     = hit_ent_q.ip;
		merged.mac    = (hit_ent_q.mac == 48'd0) ? cmd_q.mac_addr : hit_ent_q.mac;
		merged.expiry = (exp_q > hit_ent_q.expiry) ? exp_q : hit_ent_q.expiry;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.op)
						OP_UPDATE, OP_LOOKUP: state_d = ST_SCAN;
						OP_QUERY, OP_TXERR, OP_PURGE: state_d = ST_PURGE;
						default: state_d = ST_ANSWER;
					endcase
				end
			end
			ST_SCAN: begin
				if (walk_done) begin
					state_d = (cmd_q.op == OP_UPDATE && !hit_q) ? ST_PURGE : ST_ANSWER;
				end
			end
			ST_PURGE: begin
				if (walk_done) begin
					state_d = ST_ANSWER;
				end
			end
			ST_ANSWER: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		we    = 1'b0;
		waddr = wr_q[IDX_W-1:0];
		wdata = rd_ent;
		res_v = 1'b0;
		res_d = '0;
		case (state_q)
			ST_PURGE: begin
				if (vld_s1) begin
					if (gone) begin
						res_v          = report_q;
						res_d.result_ip = rd_ent.ip;
					end else begin
						we = 1'b1;
					end
				end
			end
			ST_ANSWER: begin
				res_v      = 1'b1;
				res_d.kind = 1'b1;
				res_d.last = 1'b1;
				if (cmd_q.op == OP_LOOKUP && hit_q) begin
					res_d.found     = 1'b1;
					res_d.result_ip = hit_ent_q.ip;
				end
				if (cmd_q.op == OP_QUERY && hit_q) begin
					res_d.found          = 1'b1;
					res_d.remaining_time = rem_q;
				end
				if (cmd_q.op == OP_UPDATE) begin
					if (hit_q) begin
						we    = 1'b1;
						waddr = hit_idx_q;
						wdata = merged;
					end else if (full_q) begin
						res_d.table_full = 1'b1;
					end else begin
						we    = 1'b1;
						waddr = count_q[IDX_W-1:0];
						wdata = '{ip: cmd_q.ip_addr, mac: cmd_q.mac_addr, expiry: exp_q};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			report_q    <= 1'b0;
			count_q     <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			full_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_v;
			if (cfg_valid && cfg_ready) begin
				report_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						rd_q   <= '0;
						wr_q   <= '0;
						hit_q  <= 1'b0;
						vld_s1 <= 1'b0;
						full_q <= (count_q == CNT_W'(TABLE_DEPTH));
					end
				end
				ST_SCAN: begin
					vld_s1 <= issue;
					if (vld_s1 && match && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (walk_done) begin
						rd_q <= '0;
					end else begin
						rd_q <= rd_q + CNT_W'(issue);
					end
				end
				ST_PURGE: begin
					rd_q   <= rd_q + CNT_W'(issue);
					vld_s1 <= issue;
					if (vld_s1 && !gone) begin
						wr_q <= wr_q + CNT_W'(1);
						if (cmd_q.op == OP_QUERY && rd_ent.ip == cmd_q.ip_addr && !hit_q) begin
							hit_q <= 1'b1;
						end
					end
					if (walk_done) begin
						count_q <= wr_q;
					end
				end
				ST_ANSWER: begin
					if (cmd_q.op == OP_UPDATE && !hit_q && !full_q) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
			exp_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end
		if (issue) begin
			idx_s1 <= rd_q[IDX_W-1:0];
		end
		if (state_q == ST_SCAN && vld_s1 && match && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_ent_q <= rd_ent;
		end
		if (state_q == ST_PURGE && vld_s1 && !gone && !hit_q) begin
			rem_q <= rd_ent.expiry - cmd_q.current_time;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PURGE |-> wr_q <= rd_q)
		else $error("compaction write overtook read");

	a_answer_from_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.last |-> $past(state_q == ST_ANSWER))
		else $error("answer outside answer state");

	a_one_answer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ANSWER |=> state_q == ST_IDLE)
		else $error("answer state held");
endmodule
`default_nettype wire

@@ rtl/core/ntx_ram.sv @@
// ----------------------------------------------------------------------------
// ntx_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ntx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
